>>> hw/rtl/cal_pkg.sv
`default_nettype none

package cal_pkg;

    // command codes on the input item
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_BLOCK   = 2'd1;
    localparam logic [1:0] CMD_UNBLOCK = 2'd2;

    // result status codes
    localparam logic [2:0] STATUS_ADMITTED     = 3'd0;
    localparam logic [2:0] STATUS_BLOCKED      = 3'd1;
    localparam logic [2:0] STATUS_TOO_MANY     = 3'd2;
    localparam logic [2:0] STATUS_RATE         = 3'd3;
    localparam logic [2:0] STATUS_BLOCK_DONE   = 3'd4;
    localparam logic [2:0] STATUS_TABLE_FULL   = 3'd5;
    localparam logic [2:0] STATUS_UNBLOCK_DONE = 3'd6;
    localparam logic [2:0] STATUS_UNKNOWN      = 3'd7;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_MAX_OPEN   = 2'd0;
    localparam logic [1:0] REG_MAX_PER_WN = 2'd1;
    localparam logic [1:0] REG_WINDOW     = 2'd2;

    localparam logic [15:0] RST_MAX_OPEN   = 16'd100;
    localparam logic [6:0]  RST_MAX_PER_WN = 7'd10;
    localparam logic [31:0] RST_WINDOW     = 32'd1000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] source_address;
        logic [31:0] now_ticks;
        logic [15:0] open_connections;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic [2:0] status;
    } t_result;

    typedef struct packed {
        logic [15:0] max_open_connections;
        logic [6:0]  max_per_window;
        logic [31:0] window_ticks;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_BLOCK,
        OP_UNBLOCK,
        OP_UNKNOWN
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
        logic [31:0] now;
        logic        too_many;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DECIDE,
        ST_PRUNE_RD,
        ST_PRUNE_CHK
    } t_back_state;

endpackage

`default_nettype wire

>>> hw/rtl/connection_admission_limiter_unit.sv
`default_nettype none

// channel    | direction | handshake                          | payload
// request    | in        | start & !busy                      | i_item (cal_pkg::t_item)
// result     | out       | o_result_valid, one cycle strobe   | o_result (cal_pkg::t_result)
// config     | in        | psel & penable & pwrite (pready=1) | pwdata at paddr[3:2]
//
// after reset a clearing pass over every block table entry empties the table, busy stays high
// with the back idle, a job is popped and the block table is scanned entry by entry, then block,
// unblock and blocked or too-many requests finish in the decide state; a request reaching the
// rate check first drops each expired ring entry; an unknown command is answered from idle
// a two-entry queue sits between the front and the back, busy rises when it is full
// results cannot be stalled; each is shown for exactly one cycle

module connection_admission_limiter_unit #(
    parameter int BLOCK_ENTRIES = 64,
    parameter int WINDOW_DEPTH  = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cal_pkg::t_item    i_item,
    output logic                   o_result_valid,
    output cal_pkg::t_result       o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cal_pkg::t_cfg           r_cfg;
    cal_pkg::t_cfg           n_cfg;
    cal_pkg::t_job           front_job;
    cal_pkg::t_job           q_job;
    cal_pkg::t_queue_status  q_status;
    logic                    push;
    logic                    pop;
    logic                    clearing;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (paddr[3:2])
                cal_pkg::REG_MAX_OPEN:   n_cfg.max_open_connections = pwdata[15:0];
                cal_pkg::REG_MAX_PER_WN: n_cfg.max_per_window       = pwdata[6:0];
                cal_pkg::REG_WINDOW:     n_cfg.window_ticks         = pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cal_pkg::REG_MAX_OPEN:   prdata = 32'(r_cfg.max_open_connections);
            cal_pkg::REG_MAX_PER_WN: prdata = 32'(r_cfg.max_per_window);
            cal_pkg::REG_WINDOW:     prdata = r_cfg.window_ticks;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_open_connections <= cal_pkg::RST_MAX_OPEN;
            r_cfg.max_per_window       <= cal_pkg::RST_MAX_PER_WN;
            r_cfg.window_ticks         <= cal_pkg::RST_WINDOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cal_front u_front (
        .i_start    (start),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_clearing (clearing),
        .o_busy     (busy),
        .o_push     (push),
        .o_job      (front_job)
    );

    cal_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (q_job),
        .o_status (q_status)
    );

    cal_back #(
        .BLOCK_ENTRIES (BLOCK_ENTRIES),
        .WINDOW_DEPTH  (WINDOW_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job          (q_job),
        .i_job_vld      (!q_status.empty),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/cal_front.sv
`default_nettype none

module cal_front (
    input  wire logic                   i_start,
    input  wire cal_pkg::t_item         i_item,
    input  wire cal_pkg::t_cfg          i_cfg,
    input  wire cal_pkg::t_queue_status i_q_status,
    input  wire logic                   i_clearing,
    output logic                        o_busy,
    output logic                        o_push,
    output cal_pkg::t_job               o_job
);

    assign o_busy = i_q_status.full | i_clearing;
    assign o_push = i_start & ~o_busy;

    always_comb begin
        case (i_item.command)
            cal_pkg::CMD_REQUEST: o_job.op = cal_pkg::OP_REQUEST;
            cal_pkg::CMD_BLOCK:   o_job.op = cal_pkg::OP_BLOCK;
            cal_pkg::CMD_UNBLOCK: o_job.op = cal_pkg::OP_UNBLOCK;
            default:              o_job.op = cal_pkg::OP_UNKNOWN;
        endcase
        o_job.addr     = i_item.source_address;
        o_job.now      = i_item.now_ticks;
        // the user must keep config stable while requests are in flight (not enforced), so the limit check runs here
        o_job.too_many = (i_item.open_connections >= i_cfg.max_open_connections);
    end

endmodule

`default_nettype wire

>>> hw/rtl/cal_queue.sv
`default_nettype none

module cal_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire cal_pkg::t_job          i_job,
    input  wire logic                   i_pop,
    output cal_pkg::t_job               o_job,
    output cal_pkg::t_queue_status      o_status
);

    cal_pkg::t_job                r_entry [cal_pkg::QUEUE_DEPTH];
    logic [cal_pkg::QPW-1:0]      r_wr_ptr;
    logic [cal_pkg::QPW-1:0]      r_rd_ptr;
    logic [cal_pkg::QCW-1:0]      r_count;
    logic [cal_pkg::QPW-1:0]      n_wr_ptr;
    logic [cal_pkg::QPW-1:0]      n_rd_ptr;
    logic [cal_pkg::QCW-1:0]      n_count;

    assign o_job           = r_entry[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == cal_pkg::QCW'(cal_pkg::QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cal_back.sv
`default_nettype none

module cal_back #(
    parameter int BLOCK_ENTRIES = 64,
    parameter int WINDOW_DEPTH  = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cal_pkg::t_cfg     i_cfg,
    input  wire cal_pkg::t_job     i_job,
    input  wire logic              i_job_vld,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   o_result_valid,
    output cal_pkg::t_result       o_result
);

    localparam int BW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int RW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = RW + 1;
    localparam logic [BW-1:0] BLK_LAST   = BW'(BLOCK_ENTRIES - 1);
    localparam logic [RW-1:0] RING_LAST  = RW'(WINDOW_DEPTH - 1);
    localparam logic [SW-1:0] RING_SIZE  = SW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] COUNT_FULL = CW'(WINDOW_DEPTH);

    // block table entry: {valid, address}
    logic [32:0]            r_blk_mem [BLOCK_ENTRIES];
    logic [31:0]            r_ring_mem [WINDOW_DEPTH];

    cal_pkg::t_back_state   r_state;
    cal_pkg::t_back_state   n_state;
    cal_pkg::t_job          r_job;
    cal_pkg::t_job          n_job;
    logic [BW-1:0]          r_scan_idx;
    logic [BW-1:0]          n_scan_idx;
    logic                   r_chk_vld;
    logic                   n_chk_vld;
    logic [BW-1:0]          r_chk_idx;
    logic                   r_hit;
    logic                   n_hit;
    logic [BW-1:0]          r_hit_idx;
    logic [BW-1:0]          n_hit_idx;
    logic                   r_free;
    logic                   n_free;
    logic [BW-1:0]          r_free_idx;
    logic [BW-1:0]          n_free_idx;
    logic [RW-1:0]          r_oldest;
    logic [RW-1:0]          n_oldest;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_res_vld;
    logic                   n_res_vld;
    cal_pkg::t_result       r_res;
    cal_pkg::t_result       n_res;
    logic [32:0]            r_blk_q;
    logic [31:0]            r_ring_q;

    logic                   blk_we;
    logic [BW-1:0]          blk_waddr;
    logic [32:0]            blk_wdata;
    logic                   ring_we;
    logic                   match;
    logic                   free_seen;
    logic [SW-1:0]          tail_sum;
    logic [RW-1:0]          tail;
    logic [31:0]            age;
    logic                   expire;
    logic                   rate_hit;

    assign o_clearing     = (r_state == cal_pkg::ST_CLEAR);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    always_comb begin
        match     = r_chk_vld & r_blk_q[32] & (r_blk_q[31:0] == r_job.addr);
        free_seen = r_chk_vld & ~r_blk_q[32];
        tail_sum  = SW'(r_oldest) + SW'(r_count);
        tail      = (tail_sum >= RING_SIZE) ? RW'(tail_sum - RING_SIZE) : RW'(tail_sum);
        // wrap-safe age of the oldest recorded accept
        age       = r_job.now - r_ring_q;
        expire    = (r_count != '0) && (age > i_cfg.window_ticks);
        rate_hit  = (r_count == COUNT_FULL) || (32'(r_count) >= 32'(i_cfg.max_per_window));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cal_pkg::ST_CLEAR: begin
                if (r_scan_idx == BLK_LAST) n_state = cal_pkg::ST_IDLE;
            end
            cal_pkg::ST_IDLE: begin
                if (i_job_vld && i_job.op != cal_pkg::OP_UNKNOWN) n_state = cal_pkg::ST_SCAN;
            end
            cal_pkg::ST_SCAN: begin
                if (r_scan_idx == BLK_LAST) n_state = cal_pkg::ST_SCAN_TAIL;
            end
            cal_pkg::ST_SCAN_TAIL: begin
                n_state = cal_pkg::ST_DECIDE;
            end
            cal_pkg::ST_DECIDE: begin
                if (r_job.op == cal_pkg::OP_REQUEST && !r_hit && !r_job.too_many) begin
                    n_state = cal_pkg::ST_PRUNE_RD;
                end else begin
                    n_state = cal_pkg::ST_IDLE;
                end
            end
            cal_pkg::ST_PRUNE_RD: begin
                n_state = cal_pkg::ST_PRUNE_CHK;
            end
            cal_pkg::ST_PRUNE_CHK: begin
                n_state = expire ? cal_pkg::ST_PRUNE_RD : cal_pkg::ST_IDLE;
            end
            default: n_state = cal_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_job      = r_job;
        n_scan_idx = r_scan_idx;
        n_chk_vld  = 1'b0;
        n_hit      = r_hit | match;
        n_hit_idx  = match ? r_chk_idx : r_hit_idx;
        n_free     = r_free | free_seen;
        n_free_idx = (free_seen && !r_free) ? r_chk_idx : r_free_idx;
        n_oldest   = r_oldest;
        n_count    = r_count;
        n_res_vld  = 1'b0;
        n_res      = r_res;
        o_pop      = 1'b0;
        blk_we     = 1'b0;
        blk_waddr  = r_scan_idx;
        blk_wdata  = '0;
        ring_we    = 1'b0;
        case (r_state)
            cal_pkg::ST_CLEAR: begin
                blk_we     = 1'b1;
                n_scan_idx = (r_scan_idx == BLK_LAST) ? '0 : r_scan_idx + 1'b1;
            end
            cal_pkg::ST_IDLE: begin
                if (i_job_vld) begin
                    o_pop      = 1'b1;
                    n_job      = i_job;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_scan_idx = '0;
                    if (i_job.op == cal_pkg::OP_UNKNOWN) begin
                        n_res_vld = 1'b1;
                        n_res     = '{accepted: 1'b0, status: cal_pkg::STATUS_UNKNOWN};
                    end
                end
            end
            cal_pkg::ST_SCAN: begin
                n_chk_vld = 1'b1;
                if (r_scan_idx != BLK_LAST) n_scan_idx = r_scan_idx + 1'b1;
            end
            cal_pkg::ST_SCAN_TAIL: begin
            end
            cal_pkg::ST_DECIDE: begin
                case (r_job.op)
                    cal_pkg::OP_REQUEST: begin
                        if (r_hit) begin
                            n_res_vld = 1'b1;
                            n_res     = '{accepted: 1'b0, status: cal_pkg::STATUS_BLOCKED};
                        end else if (r_job.too_many) begin
                            n_res_vld = 1'b1;
                            n_res     = '{accepted: 1'b0, status: cal_pkg::STATUS_TOO_MANY};
                        end
                    end
                    cal_pkg::OP_BLOCK: begin
                        n_res_vld = 1'b1;
                        n_res     = '{accepted: 1'b0, status: cal_pkg::STATUS_BLOCK_DONE};
                        if (!r_hit) begin
                            if (r_free) begin
                                blk_we    = 1'b1;
                                blk_waddr = r_free_idx;
                                blk_wdata = {1'b1, r_job.addr};
                            end else begin
                                n_res.status = cal_pkg::STATUS_TABLE_FULL;
                            end
                        end
                    end
                    cal_pkg::OP_UNBLOCK: begin
                        n_res_vld = 1'b1;
                        n_res     = '{accepted: 1'b0, status: cal_pkg::STATUS_UNBLOCK_DONE};
                        if (r_hit) begin
                            blk_we    = 1'b1;
                            blk_waddr = r_hit_idx;
                            blk_wdata = {1'b0, r_job.addr};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            cal_pkg::ST_PRUNE_RD: begin
            end
            cal_pkg::ST_PRUNE_CHK: begin
                if (expire) begin
                    n_oldest = (r_oldest == RING_LAST) ? '0 : r_oldest + 1'b1;
                    n_count  = r_count - 1'b1;
                end else if (rate_hit) begin
                    n_res_vld = 1'b1;
                    n_res     = '{accepted: 1'b0, status: cal_pkg::STATUS_RATE};
                end else begin
                    ring_we   = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_res_vld = 1'b1;
                    n_res     = '{accepted: 1'b1, status: cal_pkg::STATUS_ADMITTED};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cal_pkg::ST_CLEAR;
            r_scan_idx <= '0;
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_oldest   <= '0;
            r_count    <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
            r_chk_vld  <= n_chk_vld;
            r_hit      <= n_hit;
            r_free     <= n_free;
            r_oldest   <= n_oldest;
            r_count    <= n_count;
            r_res_vld  <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_chk_idx  <= r_scan_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    // block table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[blk_waddr] <= blk_wdata;
        end
        r_blk_q <= r_blk_mem[r_scan_idx];
    end

    // accept time ring
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[tail] <= r_job.now;
        end
        r_ring_q <= r_ring_mem[r_oldest];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("ring count above depth");

    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cal_pkg::ST_CLEAR |-> !r_res_vld)
        else $error("result during clearing pass");

    a_accept_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld && r_res.accepted |-> r_res.status == cal_pkg::STATUS_ADMITTED)
        else $error("accepted flag with wrong status");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_job_vld)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
